### sv/lts_pkg.sv
// Shared types, constants and helper functions of the Lisp token scanner.
package lts_pkg;

    // Token kinds
    localparam logic [3:0] K_LPAREN = 4'd0;
    localparam logic [3:0] K_RPAREN = 4'd1;
    localparam logic [3:0] K_EQ     = 4'd2;
    localparam logic [3:0] K_INT    = 4'd3;
    localparam logic [3:0] K_REAL   = 4'd4;
    localparam logic [3:0] K_STR    = 4'd5;
    localparam logic [3:0] K_IDENT  = 4'd6;
    localparam logic [3:0] K_KW0    = 4'd7;
    localparam logic [3:0] K_ERROR  = 4'd15;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [9:0] FRAC_CAP = 10'd1023;
    localparam int         NUM_KW   = 8;

    // Keyword text, byte p of keyword k at bits [8p+7:8p]
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0000_0000_6669,   // if
        64'h0000_656e_6966_6564,   // define
        64'h0079_616c_7073_6964,   // display
        64'h0000_6164_626d_616c,   // lambda
        64'h0000_0000_0074_656c,   // let
        64'h0000_0000_0072_6463,   // cdr
        64'h0000_0000_0072_6163,   // car
        64'h0000_0000_646e_6f63    // cond
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd2, 3'd6, 3'd7, 3'd6, 3'd3, 3'd3, 3'd3, 3'd4
    };

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] int_part;
        logic [31:0] frac_value;
        logic [9:0]  frac_digits;
        logic [9:0]  lexeme_length;
        logic        last_of_run;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    // acc * 10 + digit, saturating at all ones
    function automatic logic [31:0] sat_dec(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
        return (|v[35:32]) ? 32'hffff_ffff : v[31:0];
    endfunction

    // Drop keywords that no longer match the identifier as a prefix
    function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] alive,
                                                    input logic [9:0] p,
                                                    input logic [7:0] c);
        logic [NUM_KW-1:0] res;
        res = alive;
        for (int k = 0; k < NUM_KW; k++) begin
            if ((p >= 10'(KW_LEN[k])) || (KW_TEXT[k][{p[2:0], 3'b000} +: 8] != c)) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    // First keyword still alive whose length matches exactly, else identifier
    function automatic logic [3:0] kw_kind(input logic [NUM_KW-1:0] alive,
                                           input logic [9:0] len);
        logic [3:0] kind;
        kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (alive[k] && (len == 10'(KW_LEN[k]))) begin
                kind = K_KW0 + 4'(k);
            end
        end
        return kind;
    endfunction

    function automatic t_result make_result(input logic [3:0] kind,
                                            input logic [31:0] ip,
                                            input logic [31:0] fv,
                                            input logic [9:0] fd,
                                            input logic [9:0] len);
        t_result r;
        r.token_kind    = kind;
        r.int_part      = ip;
        r.frac_value    = fv;
        r.frac_digits   = fd;
        r.lexeme_length = len;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

endpackage

### sv/lts_scan_core.sv
// Scanner state and per-byte next-state and token logic.
module lts_scan_core import lts_pkg::*; #(
    parameter int MAX_LEXEME = 1023
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_res_n
);

    localparam int         LEN_CAP_I = (MAX_LEXEME < 1023) ? MAX_LEXEME : 1023;
    localparam logic [9:0] LEN_CAP   = 10'(LEN_CAP_I);

    typedef enum logic [2:0] {
        M_IDLE, M_INT, M_FRAC, M_STR, M_IDENT, M_ERR
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [31:0]       r_int, n_int;
    logic [31:0]       r_frac, n_frac;
    logic [9:0]        r_fcnt, n_fcnt;
    logic [9:0]        r_len, n_len;
    logic [NUM_KW-1:0] r_alive, n_alive;

    // Fresh scan of the byte from idle
    t_mode             idle_mode;
    logic [31:0]       idle_int;
    logic [9:0]        idle_len;
    logic [NUM_KW-1:0] idle_alive;
    logic              idle_v;
    t_result           idle_tok;

    logic              ev_a, ev_b, do_idle;
    t_result           tok_a;

    always_comb begin
        idle_mode  = M_IDLE;
        idle_int   = 32'd0;
        idle_len   = 10'd0;
        idle_alive = '1;
        idle_v     = 1'b0;
        idle_tok   = make_result(K_ERROR, 32'd0, 32'd0, 10'd0, 10'd0);
        if (i_char == CH_LPAREN) begin
            idle_v   = 1'b1;
            idle_tok = make_result(K_LPAREN, 32'd0, 32'd0, 10'd0, 10'd0);
        end else if (i_char == CH_RPAREN) begin
            idle_v   = 1'b1;
            idle_tok = make_result(K_RPAREN, 32'd0, 32'd0, 10'd0, 10'd0);
        end else if (i_char == CH_EQ) begin
            idle_v   = 1'b1;
            idle_tok = make_result(K_EQ, 32'd0, 32'd0, 10'd0, 10'd0);
        end else if (is_space(i_char)) begin
            idle_mode = M_IDLE;
        end else if (is_digit(i_char)) begin
            idle_mode = M_INT;
            idle_int  = {28'd0, i_char[3:0]};
        end else if (i_char == CH_QUOTE) begin
            idle_mode = M_STR;
        end else if (is_alpha(i_char)) begin
            idle_mode  = M_IDENT;
            idle_alive = kw_filter('1, 10'd0, i_char);
            idle_len   = 10'd1;
        end else begin
            idle_mode = M_ERR;
            idle_v    = 1'b1;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_len   = r_len;
        n_alive = r_alive;
        ev_a    = 1'b0;
        do_idle = 1'b0;
        tok_a   = make_result(K_ERROR, 32'd0, 32'd0, 10'd0, 10'd0);
        if (i_eoi) begin
            unique case (r_mode)
                M_INT: begin
                    ev_a  = 1'b1;
                    tok_a = make_result(K_INT, r_int, 32'd0, 10'd0, 10'd0);
                end
                M_FRAC: begin
                    ev_a  = 1'b1;
                    tok_a = make_result(K_REAL, r_int, r_frac, r_fcnt, 10'd0);
                end
                M_STR: begin
                    ev_a = 1'b1;
                end
                M_IDENT: begin
                    ev_a  = 1'b1;
                    tok_a = make_result(kw_kind(r_alive, r_len), 32'd0, 32'd0, 10'd0, r_len);
                end
                default: begin
                    ev_a = 1'b0;
                end
            endcase
            n_mode  = M_IDLE;
            n_int   = 32'd0;
            n_frac  = 32'd0;
            n_fcnt  = 10'd0;
            n_len   = 10'd0;
            n_alive = '1;
        end else begin
            unique case (r_mode)
                M_INT: begin
                    if (is_digit(i_char)) begin
                        n_int = sat_dec(r_int, i_char[3:0]);
                    end else if (i_char == CH_DOT) begin
                        n_mode = M_FRAC;
                    end else begin
                        ev_a    = 1'b1;
                        tok_a   = make_result(K_INT, r_int, 32'd0, 10'd0, 10'd0);
                        do_idle = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(i_char)) begin
                        n_frac = sat_dec(r_frac, i_char[3:0]);
                        if (r_fcnt < FRAC_CAP) begin
                            n_fcnt = r_fcnt + 10'd1;
                        end
                    end else begin
                        ev_a    = 1'b1;
                        tok_a   = make_result(K_REAL, r_int, r_frac, r_fcnt, 10'd0);
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if ((i_char == CH_QUOTE) || (i_char == CH_NUL) || (i_char == CH_NL)) begin
                        ev_a    = 1'b1;
                        n_mode  = (i_char == CH_QUOTE) ? M_IDLE : M_ERR;
                        if (i_char == CH_QUOTE) begin
                            tok_a = make_result(K_STR, 32'd0, 32'd0, 10'd0, r_len);
                        end
                        n_int   = 32'd0;
                        n_frac  = 32'd0;
                        n_fcnt  = 10'd0;
                        n_len   = 10'd0;
                        n_alive = '1;
                    end else if (r_len < LEN_CAP) begin
                        n_len = r_len + 10'd1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(i_char) || is_digit(i_char)) begin
                        n_alive = kw_filter(r_alive, r_len, i_char);
                        if (r_len < LEN_CAP) begin
                            n_len = r_len + 10'd1;
                        end
                    end else begin
                        ev_a    = 1'b1;
                        tok_a   = make_result(kw_kind(r_alive, r_len), 32'd0, 32'd0, 10'd0,
                                              r_len);
                        do_idle = 1'b1;
                    end
                end
                M_ERR: begin
                    n_mode = M_ERR;
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
            if (do_idle) begin
                n_mode  = idle_mode;
                n_int   = idle_int;
                n_frac  = 32'd0;
                n_fcnt  = 10'd0;
                n_len   = idle_len;
                n_alive = idle_alive;
            end
        end
    end

    assign ev_b = do_idle && idle_v;

    // Pack up to two results, flag the final one
    always_comb begin
        o_res0 = ev_a ? tok_a : idle_tok;
        o_res1 = idle_tok;
        if (ev_a && ev_b) begin
            o_res_n            = 2'd2;
            o_res1.last_of_run = 1'b1;
        end else if (ev_a || ev_b) begin
            o_res_n            = 2'd1;
            o_res0.last_of_run = 1'b1;
        end else begin
            o_res_n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_int   <= 32'd0;
            r_frac  <= 32'd0;
            r_fcnt  <= 10'd0;
            r_len   <= 10'd0;
            r_alive <= '1;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_len   <= n_len;
            r_alive <= n_alive;
        end
    end

endmodule

### sv/lts_out_fifo.sv
// Four-entry result queue that takes up to two results and gives one per cycle while i_pop is set.
module lts_out_fifo import lts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_data0,
    input  t_result    i_data1,
    input  logic       i_pop,
    output t_result    o_data,
    output logic       o_valid,
    output logic [2:0] o_count
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= r_wr + i_push_n;
            r_rd    <= r_rd + {1'b0, i_pop};
            r_count <= r_count + {1'b0, i_push_n} - {2'b00, i_pop};
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_valid = (r_count != 3'd0);
    assign o_count = r_count;

endmodule

### sv/lisp_token_scanner_unit.sv
// Top level of the Lisp token scanner: input register, scan core and result queue.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one source byte per
//   transaction in i_char_code; i_end_of_input set flushes the pending token,
//   clears a sticky error and ignores the byte.
//   Output channel (o_out_valid / i_out_ready) carries one token per
//   transaction; o_last_of_run marks the final token caused by an input byte.
//   One input byte gives zero, one or two tokens.
// Timing
//   A byte lands in the input register, is scanned once the queue has room
//   for two tokens and its tokens are written to a four-entry queue, whose
//   head drives the output. One byte is taken every cycle while the queue
//   holds at most two tokens; a byte that gives two tokens takes two output
//   transactions, which sets the sustained rate when such bytes come in a row.
// Reset and stall
//   i_rst_n (synchronous, active low) empties the queue and returns the
//   scanner to idle with all accumulators cleared. When the receiver stalls,
//   the queue fills, the scan stage holds its byte and o_in_ready drops.
module lisp_token_scanner_unit import lts_pkg::*; #(
    parameter int MAX_LEXEME = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_int_part,
    output logic [31:0] o_frac_value,
    output logic [9:0]  o_frac_digits,
    output logic [9:0]  o_lexeme_length,
    output logic        o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eoi;

    logic       proc_fire;
    logic       pop;
    logic [2:0] q_count;
    logic [1:0] res_n;
    logic [1:0] push_n;
    t_result    res0, res1, q_data;

    // Scan the held byte only when the queue has room for two tokens
    assign proc_fire  = r_in_valid && (q_count <= 3'd2);
    assign o_in_ready = !r_in_valid || proc_fire;
    assign push_n     = proc_fire ? res_n : 2'd0;
    assign pop        = o_out_valid && i_out_ready;

    // Hold the byte until the scan stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_code;
            r_eoi  <= i_end_of_input;
        end
    end

    lts_scan_core #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_char  (r_char),
        .i_eoi   (r_eoi),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_res_n (res_n)
    );

    lts_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_data0  (res0),
        .i_data1  (res1),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_valid  (o_out_valid),
        .o_count  (q_count)
    );

    assign o_token_kind    = q_data.token_kind;
    assign o_int_part      = q_data.int_part;
    assign o_frac_value    = q_data.frac_value;
    assign o_frac_digits   = q_data.frac_digits;
    assign o_lexeme_length = q_data.lexeme_length;
    assign o_last_of_run   = q_data.last_of_run;

`ifndef NO_ASSERTIONS
    // Queue never overflows
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= 3'd4)
        else $error("result queue overflow");

    // Queue occupancy follows pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        q_count == 3'($past(q_count) + {1'b0, $past(push_n)} - {2'b00, $past(pop)}))
        else $error("result queue count mismatch");

    // Input stalls only while a byte is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input stalled with empty input register");

    // Two tokens from one byte: only the second is flagged last
    a_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && res_n == 2'd2) |-> (!res0.last_of_run && res1.last_of_run))
        else $error("bad last flag on token pair");
`endif

endmodule
